### design/wtmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wtmc_pkg;

	localparam int MAX_DATES  = 256;
	localparam int TRIM_COUNT = 2;
	localparam int VALUE_W    = 16;
	localparam int DAY_W      = 9;
	localparam int CNT_W      = 9;
	localparam int SUM_W      = 24;
	localparam int DIVR_W     = 8;
	localparam int WIN_W      = 11;
	localparam int DIV_STEPS  = SUM_W;
	localparam int STEP_W     = 5;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_DAY  = 1'b0,
		REG_PERIOD_DAYS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic step_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

### design/wtmc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module wtmc_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             s_axis_tvalid,
	input  wire             s_axis_tlast,
	output logic            s_axis_tready,
	input  wtmc_pkg::status_t st,
	output wtmc_pkg::cmd_t  cmd
);
	import wtmc_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid && s_axis_tlast) state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (st.step_last) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (st.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		cmd           = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.accept    = s_axis_tvalid;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
			end
			ST_DONE: begin
				cmd.finish = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

### design/wtmc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module wtmc_dp (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [wtmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [wtmc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire  [wtmc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	output logic [wtmc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	input  wtmc_pkg::cmd_t                      cmd,
	output wtmc_pkg::status_t                   st
);
	import wtmc_pkg::*;

	logic [DAY_W-1:0]   center_q, period_q;
	logic [SUM_W-1:0]   sum_q;
	logic [VALUE_W-1:0] min_q, max_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [SUM_W-1:0]   dvd_q;
	logic [DIVR_W-1:0]  divisor_q, rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W-1:0]   res_cnt_q;
	logic [VALUE_W-1:0] res_min_q;

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [CNT_W-1:0]   out_cnt_q;

	logic [VALUE_W-1:0]      in_value;
	logic [DAY_W-1:0]        in_day;
	logic signed [WIN_W-1:0] win_lo, win_hi, day_s;
	logic                    use_sample;
	logic [CNT_W-1:0]        cnt_trim;
	logic [DIVR_W:0]         shifted;
	logic [DIVR_W+1:0]       diff;
	logic                    ge;
	logic [VALUE_W-1:0]      result;

	assign in_value = s_axis_tdata[VALUE_W-1:0];
	assign in_day   = s_axis_tdata[VALUE_W+DAY_W-1:VALUE_W];

	assign day_s  = $signed({2'b00, in_day});
	assign win_lo = $signed({2'b00, center_q}) - $signed({3'b000, period_q[DAY_W-1:1]});
	assign win_hi = win_lo + $signed({2'b00, period_q});

	assign use_sample = (in_value != '0) && (day_s >= win_lo) && (day_s <= win_hi)
		&& (cnt_q < CNT_W'(MAX_DATES));

	assign cnt_trim = cnt_q - CNT_W'(TRIM_COUNT);

	assign shifted = {rem_q, dvd_q[SUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor_q};
	assign ge      = !diff[DIVR_W+1];

	always_comb begin
		if (res_cnt_q > CNT_W'(TRIM_COUNT)) begin
			result = dvd_q[VALUE_W-1:0];
		end else if (res_cnt_q == CNT_W'(TRIM_COUNT)) begin
			result = res_min_q;
		end else begin
			result = '0;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			period_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_DAY:  center_q <= cfg_data;
				REG_PERIOD_DAYS: period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// series accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			min_q <= '1;
			max_q <= '0;
			cnt_q <= '0;
		end else if (cmd.load) begin
			sum_q <= '0;
			min_q <= '1;
			max_q <= '0;
			cnt_q <= '0;
		end else if (cmd.accept && use_sample) begin
			sum_q <= sum_q + {{(SUM_W-VALUE_W){1'b0}}, in_value};
			if (in_value < min_q) min_q <= in_value;
			if (in_value > max_q) max_q <= in_value;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// restoring divider, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q     <= sum_q - {{(SUM_W-VALUE_W){1'b0}}, min_q}
				- {{(SUM_W-VALUE_W){1'b0}}, max_q};
			divisor_q <= cnt_trim[DIVR_W-1:0];
			rem_q     <= '0;
			step_q    <= '0;
			res_cnt_q <= cnt_q;
			res_min_q <= min_q;
		end else if (cmd.step) begin
			rem_q  <= ge ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
			dvd_q  <= {dvd_q[SUM_W-2:0], ge};
			step_q <= step_q + STEP_W'(1);
		end
	end

	assign st.step_last = (step_q == STEP_W'(DIV_STEPS - 1));
	assign st.out_free  = !out_valid_q || m_axis_tready;

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_value_q <= result;
			out_cnt_q   <= res_cnt_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W-VALUE_W-CNT_W){1'b0}}, out_cnt_q, out_value_q};

endmodule
`default_nettype wire

### design/windowed_trimmed_mean_composite.sv
// Per-pixel trimmed-mean compositor. Feed the samples of one pixel series in
// date order, one word each; tlast marks the final sample. A sample counts when
// its value is nonzero and its day lies in [center - period/2, that + period];
// at most 256 samples a series are counted. Non-final words are taken back to
// back while the block is idle. The final word starts a bit-serial divide of
// 24 steps, so after it no word is taken until the load, the divide steps and
// the hand-over of the result to the output register are done (the hand-over
// waits while the previous result still waits there); the result word may
// then wait in the output register while the next series streams in.
// Configuration writes are to be made only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module windowed_trimmed_mean_composite (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [wtmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [wtmc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire  [wtmc_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // sample_value, sample_day
	input  wire                                s_axis_tlast,  // last_sample
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	output logic [wtmc_pkg::M_TDATA_W-1:0]     m_axis_tdata   // composite_value, used_count
);
	import wtmc_pkg::*;

	cmd_t    cmd;
	status_t st;

	wtmc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tready (s_axis_tready),
		.st            (st),
		.cmd           (cmd)
	);

	wtmc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cmd           (cmd),
		.st            (st)
	);

	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_axis_tvalid)
		else $error("result not presented after finish");

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !s_axis_tready)
		else $error("input taken during divide");

	a_few_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[VALUE_W+CNT_W-1:VALUE_W] < CNT_W'(TRIM_COUNT)))
		|-> (m_axis_tdata[VALUE_W-1:0] == '0))
		else $error("nonzero composite with too few samples");

	a_step_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && st.step_last) |=> !cmd.step)
		else $error("divider ran past its last step");

endmodule
`default_nettype wire
